// ----- rtl/pdpa_pkg.sv -----
// Shared types, constants and codes for the pointer deadband peak averager.
// No dependencies; every other file in rtl/ but pdpa_div imports this package.
package pdpa_pkg;

  // Field widths
  localparam int PIX_W    = 13;
  localparam int EDGE_W   = 12;
  localparam int SIZE_W   = 13;
  localparam int FRAMES_W = 5;
  localparam int GAIN_W   = 16;
  localparam int PEAK_W   = 16;
  localparam int DRIVE_W  = 29;

  // Average in 1/32 pixel: |avg| never exceeds the largest peak times 16
  localparam int AVG_W    = 20;
  localparam int PROD_W   = AVG_W + 1 + GAIN_W;

  // Channel packing
  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 88;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Defaults for top-level parameters
  localparam int MAX_FRAMES_DEF = 16;
  localparam int QDEPTH_DEF     = 2;

  // Deadband in half pixels (1.5 pixels)
  localparam int DEADBAND = 3;

  // Drive saturation limits
  localparam int DRIVE_MAX = 268435455;
  localparam int DRIVE_MIN = -268435456;

  // Command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_FRAMES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_GAIN = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLL_GAIN  = 4'd7;

  // Register reset values
  localparam logic [GAIN_W-1:0] TURN_GAIN_RST  = 16'hFF7D;  // -131
  localparam logic [GAIN_W-1:0] PITCH_GAIN_RST = 16'hFF7D;  // -131
  localparam logic [GAIN_W-1:0] ROLL_GAIN_RST  = 16'h0148;  // 328

  // Configuration register file
  typedef struct packed {
    logic [FRAMES_W-1:0] avg_frames;
    logic [EDGE_W-1:0]   win_left;
    logic [EDGE_W-1:0]   win_top;
    logic [SIZE_W-1:0]   win_width;
    logic [SIZE_W-1:0]   win_height;
    logic [GAIN_W-1:0]   turn_gain;
    logic [GAIN_W-1:0]   pitch_gain;
    logic [GAIN_W-1:0]   roll_gain;
  } cfg_t;

  // Frame job handed from front to back on a tick
  typedef struct packed {
    logic [PEAK_W-1:0] peak_x;
    logic [PEAK_W-1:0] peak_y;
    logic              roll_held;
  } job_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PASS,
    BK_WRITE,
    BK_SUM,
    BK_LAST,
    BK_DIVGO,
    BK_DIVW,
    BK_MUL,
    BK_SAT,
    BK_OUT
  } bk_state_t;

endpackage

// ----- rtl/pdpa_front.sv -----
// Front end: accepts items, holds the per-axis peaks and turns a tick into a job.
// Depends on pdpa_pkg.
module pdpa_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [pdpa_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [pdpa_pkg::IN_USER_W-1:0] in_tuser,
  input  pdpa_pkg::cfg_t               cfg,
  input  logic                         q_full,
  output logic                         q_push,
  output pdpa_pkg::job_t               q_job
);
  import pdpa_pkg::*;

  logic [PEAK_W-1:0] peak_x_r, peak_x_nxt;
  logic [PEAK_W-1:0] peak_y_r, peak_y_nxt;
  logic [PIX_W-1:0]  pix_x, pix_y;
  logic              cmd, roll_held, accept, win_ok;
  logic signed [PEAK_W-1:0] dx, dy;

  function automatic logic [PEAK_W-1:0] mag(input logic [PEAK_W-1:0] v);
    return v[PEAK_W-1] ? PEAK_W'(-$signed(v)) : v;
  endfunction

  // Keep d when it lies outside the deadband and beats the held peak
  function automatic logic [PEAK_W-1:0] hold(input logic [PEAK_W-1:0] pk,
                                             input logic [PEAK_W-1:0] d);
    logic [PEAK_W-1:0] md;
    md = mag(d);
    if ((md > PEAK_W'(DEADBAND)) && (md > mag(pk))) return d;
    return pk;
  endfunction

  assign pix_x     = in_tdata[PIX_W-1:0];
  assign pix_y     = in_tdata[2*PIX_W-1:PIX_W];
  assign cmd       = in_tuser[0];
  assign roll_held = in_tuser[1];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign win_ok    = (cfg.win_width >= SIZE_W'(2)) && (cfg.win_height >= SIZE_W'(2));

  // Offsets from the window center in half pixels
  assign dx = $signed({2'b00, pix_x, 1'b0}) - $signed({3'b000, cfg.win_left, 1'b0})
            - $signed({3'b000, cfg.win_width});
  assign dy = $signed({2'b00, pix_y, 1'b0}) - $signed({3'b000, cfg.win_top, 1'b0})
            - $signed({3'b000, cfg.win_height});

  // Hand the held peaks over on a tick
  assign q_push = accept && (cmd == CMD_TICK);
  always_comb begin
    q_job.peak_x    = peak_x_r;
    q_job.peak_y    = peak_y_r;
    q_job.roll_held = roll_held;
  end

  // Update or clear the peaks
  always_comb begin
    peak_x_nxt = peak_x_r;
    peak_y_nxt = peak_y_r;
    if (accept) begin
      if (cmd == CMD_TICK) begin
        peak_x_nxt = '0;
        peak_y_nxt = '0;
      end else if (win_ok) begin
        peak_x_nxt = hold(peak_x_r, dx);
        peak_y_nxt = hold(peak_y_r, dy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_x_r <= '0;
      peak_y_r <= '0;
    end else begin
      peak_x_r <= peak_x_nxt;
      peak_y_r <= peak_y_nxt;
    end
  end

endmodule

// ----- rtl/pdpa_fifo.sv -----
// Short job queue between front and back so each side can stall on its own.
// Depends on pdpa_pkg for the job type.
module pdpa_fifo #(
  parameter int DEPTH = pdpa_pkg::QDEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pdpa_pkg::job_t push_job,
  input  logic           pop,
  output pdpa_pkg::job_t pop_job,
  output logic           full,
  output logic           empty
);
  import pdpa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t              slot_mem [DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = slot_mem[rptr_r];

  // Advance pointers and count
  always_comb begin
    wptr_nxt  = push ? bump(wptr_r) : wptr_r;
    rptr_nxt  = pop ? bump(rptr_r) : rptr_r;
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) slot_mem[wptr_r] <= push_job;
  end

endmodule

// ----- rtl/pdpa_div.sv -----
// Signed divide by an unsigned count, one quotient bit per cycle, truncating.
// No package dependency; widths come from the instantiating module.
module pdpa_div #(
  parameter int DIVD_W = 25,
  parameter int DVSR_W = 5,
  parameter int QUO_W  = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIVD_W-1:0]        dividend,
  input  logic [DVSR_W-1:0]        divisor,
  output logic                     done,
  output logic [QUO_W-1:0]         quotient
);

  localparam int CNT_W = (DIVD_W > 1) ? $clog2(DIVD_W) : 1;

  logic [DVSR_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DVSR_W-1:0] dvsr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt, neg_r;
  logic [DVSR_W:0]   shifted, trial;
  logic [QUO_W-1:0]  qmag;

  // One restoring step
  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign trial   = shifted - {1'b0, dvsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend[DIVD_W-1] ? DIVD_W'(-$signed(dividend)) : dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DVSR_W]) begin
        rem_nxt = trial[DVSR_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVSR_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (start) begin
      dvsr_r <= divisor;
      neg_r  <= dividend[DIVD_W-1];
    end
  end

  // Restore the sign
  assign qmag     = quo_r[QUO_W-1:0];
  assign quotient = neg_r ? QUO_W'(-$signed(qmag)) : qmag;
  assign done     = done_r;

endmodule

// ----- rtl/pdpa_back.sv -----
// Back end: frame ring, sum, average, gain multiply, saturate and result register.
// Depends on pdpa_pkg and pdpa_div.
module pdpa_back #(
  parameter int MAX_FRAMES = pdpa_pkg::MAX_FRAMES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pdpa_pkg::cfg_t                  cfg,
  input  logic                            q_empty,
  input  pdpa_pkg::job_t                  q_job,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pdpa_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [pdpa_pkg::OUT_USER_W-1:0] out_tuser
);
  import pdpa_pkg::*;

  localparam int N_W    = $clog2(MAX_FRAMES + 1);
  localparam int AW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int SUM_W  = PEAK_W + N_W;
  localparam int DIVD_W = SUM_W + 4;
  localparam int FLR_W  = PROD_W - 4;

  localparam logic signed [PROD_W:0]    RND    = (PROD_W + 1)'(16);
  localparam logic signed [FLR_W-1:0]   SAT_HI = FLR_W'(DRIVE_MAX);
  localparam logic signed [FLR_W-1:0]   SAT_LO = FLR_W'(DRIVE_MIN);

  bk_state_t state_r, state_nxt;

  job_t               job_r;
  logic [N_W-1:0]     n_r, n_eff, ws_r, slot, cnt_r;
  logic [31:0]        n_full;
  logic [2*PEAK_W-1:0] ring_mem [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] ring_vld_r;
  logic [2*PEAK_W-1:0] rd_data_r;
  logic               rd_live_r, rd_pend_r;
  logic               ring_we, rd_en, div_go;
  logic [SUM_W-1:0]   acc_x_r, acc_y_r;
  logic [AVG_W-1:0]   avg_x_r, avg_y_r, quo_x, quo_y;
  logic               done_x, done_y;
  logic [AVG_W:0]     op_a, op_b;
  logic [GAIN_W-1:0]  gain_a;
  logic [PROD_W-1:0]  prod_a_r, prod_b_r;
  logic [DRIVE_W-1:0] drv_a, drv_b, turn_d, pitch_d, roll_d;
  logic [DRIVE_W-1:0] turn_r, pitch_r, roll_r;
  logic [OUT_USER_W-1:0] flags_r;

  // Round with ties up, floor by 32, saturate to the drive range
  function automatic logic [DRIVE_W-1:0] sat_drive(input logic [PROD_W-1:0] prod);
    logic signed [PROD_W:0]  biased;
    logic signed [FLR_W-1:0] flr;
    biased = $signed({prod[PROD_W-1], prod}) + RND;
    flr    = biased[PROD_W:5];
    if (flr > SAT_HI) return {1'b0, {(DRIVE_W - 1){1'b1}}};
    if (flr < SAT_LO) return {1'b1, {(DRIVE_W - 1){1'b0}}};
    return flr[DRIVE_W-1:0];
  endfunction

  // Active frame count, clamped to the ring depth
  assign n_full = (32'(cfg.avg_frames) > MAX_FRAMES) ? MAX_FRAMES : 32'(cfg.avg_frames);
  assign n_eff  = n_full[N_W-1:0];
  assign slot   = (ws_r >= n_r) ? '0 : ws_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (!q_empty) state_nxt = (n_eff == '0) ? BK_PASS : BK_WRITE;
      BK_PASS:  state_nxt = BK_MUL;
      BK_WRITE: state_nxt = BK_SUM;
      BK_SUM:   if (cnt_r == n_r - 1'b1) state_nxt = BK_LAST;
      BK_LAST:  state_nxt = BK_DIVGO;
      BK_DIVGO: state_nxt = BK_DIVW;
      BK_DIVW:  if (done_x && done_y) state_nxt = BK_MUL;
      BK_MUL:   state_nxt = BK_SAT;
      BK_SAT:   state_nxt = BK_OUT;
      BK_OUT:   if (out_tready) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop      = (state_r == BK_IDLE) && !q_empty;
    ring_we    = (state_r == BK_WRITE);
    rd_en      = (state_r == BK_SUM);
    div_go     = (state_r == BK_DIVGO);
    out_tvalid = (state_r == BK_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      ws_r       <= '0;
      ring_vld_r <= '0;
      rd_pend_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_en;
      if (ring_we) begin
        ws_r <= slot + 1'b1;
        ring_vld_r[slot[AW-1:0]] <= 1'b1;
      end
    end
  end

  // Ring memory: write the new frame, read one entry per cycle for the sum
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[slot[AW-1:0]] <= {job_r.peak_x, job_r.peak_y};
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= ring_mem[cnt_r[AW-1:0]];
      rd_live_r <= ring_vld_r[cnt_r[AW-1:0]];
    end
  end

  // Job capture, read count and accumulation
  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
      n_r   <= n_eff;
    end
    if (ring_we) begin
      cnt_r   <= '0;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else begin
      if (rd_en) cnt_r <= cnt_r + 1'b1;
      if (rd_pend_r && rd_live_r) begin
        acc_x_r <= acc_x_r + {{(SUM_W - PEAK_W){rd_data_r[2*PEAK_W-1]}},
                              rd_data_r[2*PEAK_W-1:PEAK_W]};
        acc_y_r <= acc_y_r + {{(SUM_W - PEAK_W){rd_data_r[PEAK_W-1]}},
                              rd_data_r[PEAK_W-1:0]};
      end
    end
  end

  // Averages: sum * 16 / n, one bit per cycle
  pdpa_div #(.DIVD_W(DIVD_W), .DVSR_W(N_W), .QUO_W(AVG_W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend({acc_x_r, 4'b0000}),
    .divisor(n_r), .done(done_x), .quotient(quo_x)
  );

  pdpa_div #(.DIVD_W(DIVD_W), .DVSR_W(N_W), .QUO_W(AVG_W)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend({acc_y_r, 4'b0000}),
    .divisor(n_r), .done(done_y), .quotient(quo_y)
  );

  // Multiplier operands: roll uses y minus x
  assign op_a   = job_r.roll_held ? ({avg_y_r[AVG_W-1], avg_y_r} - {avg_x_r[AVG_W-1], avg_x_r})
                                  : {avg_x_r[AVG_W-1], avg_x_r};
  assign op_b   = {avg_y_r[AVG_W-1], avg_y_r};
  assign gain_a = job_r.roll_held ? cfg.roll_gain : cfg.turn_gain;

  // Saturated drives and their flags
  assign drv_a   = sat_drive(prod_a_r);
  assign drv_b   = sat_drive(prod_b_r);
  assign turn_d  = job_r.roll_held ? '0 : drv_a;
  assign pitch_d = job_r.roll_held ? '0 : drv_b;
  assign roll_d  = job_r.roll_held ? drv_a : '0;

  always_ff @(posedge clk) begin
    case (state_r)
      BK_PASS: begin
        avg_x_r <= {job_r.peak_x, 4'b0000};
        avg_y_r <= {job_r.peak_y, 4'b0000};
      end
      BK_DIVW: begin
        if (done_x && done_y) begin
          avg_x_r <= quo_x;
          avg_y_r <= quo_y;
        end
      end
      BK_MUL: begin
        prod_a_r <= {{GAIN_W{op_a[AVG_W]}}, op_a} * {{(AVG_W + 1){gain_a[GAIN_W-1]}}, gain_a};
        prod_b_r <= {{GAIN_W{op_b[AVG_W]}}, op_b}
                  * {{(AVG_W + 1){cfg.pitch_gain[GAIN_W-1]}}, cfg.pitch_gain};
      end
      BK_SAT: begin
        turn_r  <= turn_d;
        pitch_r <= pitch_d;
        roll_r  <= roll_d;
        flags_r <= {roll_d != '0, pitch_d != '0, turn_d != '0};
      end
      default: begin
      end
    endcase
  end

  assign out_tdata = {1'b0, roll_r, pitch_r, turn_r};
  assign out_tuser = flags_r;

endmodule

// ----- rtl/pointer_deadband_peak_average_top.sv -----
// Top level of the pointer deadband peak averager: register file, front, queue, back.
// Depends on pdpa_pkg, pdpa_front, pdpa_fifo, pdpa_div and pdpa_back.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: pixel_x, pixel_y; tuser: command,
//          |     |                    |   roll_held
//  out_    | out | out_tvalid/tready  | tdata: turn, pitch, roll drive; tuser: flags
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data (always ready)
//
// Samples and ticks are held off only while the job queue is full. With averaging off a
// tick's peaks go straight to the gain multiply; with n frames averaged the result also
// waits on the ring sum, which reads one entry at a time, and the one-bit-per-cycle dividers.
// The job queue lets the front keep taking items while a result waits on out_tready, until it fills.
// Reset is synchronous; ring entries carry valid bits cleared at once, no clearing pass.
module pointer_deadband_peak_average_top #(
  parameter int MAX_FRAMES = pdpa_pkg::MAX_FRAMES_DEF,
  parameter int QDEPTH     = pdpa_pkg::QDEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: pixel_x[12:0], pixel_y[25:13], zero pad
  // in_tuser: command[0], roll_held[1]
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pdpa_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [pdpa_pkg::IN_USER_W-1:0]  in_tuser,
  // out_tdata: turn_drive[28:0], pitch_drive[57:29], roll_drive[86:58], zero pad
  // out_tuser: turn_valid[0], pitch_valid[1], roll_valid[2]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pdpa_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [pdpa_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pdpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pdpa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pdpa_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  job_t push_job, pop_job;
  logic q_push, q_pop, q_full, q_empty;

  assign cfg_ready = 1'b1;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_AVG_FRAMES: cfg_nxt.avg_frames = cfg_data[FRAMES_W-1:0];
        CFG_WIN_LEFT:   cfg_nxt.win_left   = cfg_data[EDGE_W-1:0];
        CFG_WIN_TOP:    cfg_nxt.win_top    = cfg_data[EDGE_W-1:0];
        CFG_WIN_WIDTH:  cfg_nxt.win_width  = cfg_data[SIZE_W-1:0];
        CFG_WIN_HEIGHT: cfg_nxt.win_height = cfg_data[SIZE_W-1:0];
        CFG_TURN_GAIN:  cfg_nxt.turn_gain  = cfg_data[GAIN_W-1:0];
        CFG_PITCH_GAIN: cfg_nxt.pitch_gain = cfg_data[GAIN_W-1:0];
        CFG_ROLL_GAIN:  cfg_nxt.roll_gain  = cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.avg_frames <= '0;
      cfg_r.win_left   <= '0;
      cfg_r.win_top    <= '0;
      cfg_r.win_width  <= '0;
      cfg_r.win_height <= '0;
      cfg_r.turn_gain  <= TURN_GAIN_RST;
      cfg_r.pitch_gain <= PITCH_GAIN_RST;
      cfg_r.roll_gain  <= ROLL_GAIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pdpa_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg(cfg_r), .q_full(q_full), .q_push(q_push), .q_job(push_job)
  );

  pdpa_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_job(push_job),
    .pop(q_pop), .pop_job(pop_job), .full(q_full), .empty(q_empty)
  );

  pdpa_back #(.MAX_FRAMES(MAX_FRAMES)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r),
    .q_empty(q_empty), .q_job(pop_job), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

// ----- rtl/pdpa_check.sv -----
// Port-level checks for the pointer deadband peak averager, bound to the top level.
// Depends on pdpa_pkg and pointer_deadband_peak_average_top.
module pdpa_check (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [pdpa_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [pdpa_pkg::OUT_USER_W-1:0] out_tuser
);
  import pdpa_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Roll mode excludes turn and pitch flags
  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> !out_tuser[0] && !out_tuser[1])
    else $error("roll flag set together with turn or pitch flag");

  // Each flag matches a nonzero drive
  a_flag_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[0] == (out_tdata[DRIVE_W-1:0] != '0))
                && (out_tuser[1] == (out_tdata[2*DRIVE_W-1:DRIVE_W] != '0))
                && (out_tuser[2] == (out_tdata[3*DRIVE_W-1:2*DRIVE_W] != '0)))
    else $error("drive flag does not match drive value");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule

bind pointer_deadband_peak_average_top pdpa_check u_check (.*);
